// ===== rtl/ddo_pkg.sv =====
// ddo_pkg: shared types, constants and helper functions of the wheel odometry block
// no dependencies; compiled first, used by the interfaces and every module
`default_nettype none

package ddo_pkg;

    // field widths
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int SCALE_W  = 32;
    localparam int TRACK_W  = 24;
    localparam int POS_W    = 48;
    localparam int ANGLE_W  = 32;
    localparam int VEL_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_TRACK  = 2'd2;

    localparam logic [TRACK_W-1:0] HALF_TRACK_RESET = 24'd15401;

    // arithmetic constants
    localparam logic [31:0] PI_Q29      = 32'd1686629713;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    localparam logic [31:0] USEC_PER_S  = 32'd1000000;
    localparam int DEFAULT_CORDIC_STEPS = 24;

    // serial divider sizes
    localparam int DIV_NUM_W = 116;
    localparam int DIV_DEN_W = 56;
    localparam int DIV_CNT_W = 7;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 7'(DIV_NUM_W - 1);

    typedef enum logic [3:0] {
        MUL_L,
        MUL_R,
        MUL_PIHT,
        MUL_C_LO,
        MUL_C_HI,
        MUL_S_LO,
        MUL_S_HI,
        MUL_X_LO,
        MUL_X_HI,
        MUL_Y_LO,
        MUL_Y_HI,
        MUL_D_LO,
        MUL_D_HI,
        MUL_HTDT
    } mul_sel_t;

    typedef enum logic {
        DEN_P,
        DEN_DT
    } den_sel_t;

    typedef enum logic [1:0] {
        NUM_DBA,
        NUM_ACC,
        NUM_ACC15
    } num_sel_t;

    typedef struct packed {
        logic     capture;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     set_dl;
        logic     set_dr;
        logic     set_diff;
        logic     acc_load;
        logic     acc_add;
        logic     den_load;
        den_sel_t den_sel;
        logic     num_load;
        num_sel_t num_sel;
        logic     div_step;
        logic     set_head;
        logic     cord_init;
        logic     cord_step;
        logic     cord_fin;
        logic     set_mx;
        logic     set_my;
        logic     pos_upd;
        logic     set_vx;
        logic     set_vy;
        logic     set_yaw;
        logic     out_load;
    } ddo_cmd_t;

    typedef struct packed {
        logic have_prev;
        logic dt_zero;
        logic div_last;
        logic cord_last;
        logic out_busy;
    } ddo_status_t;

    // arctangent of 2^-i as binary angle
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // signed 32-bit saturation of a quotient magnitude
    function automatic logic [31:0] sat32(input logic neg, input logic ovf,
                                          input logic [32:0] q);
        logic [31:0] r;
        if (!neg) begin
            if (ovf || (q > 33'h07FFFFFFF)) r = 32'h7FFFFFFF;
            else r = q[31:0];
        end
        else begin
            if (ovf || (q > 33'h080000000)) r = 32'h80000000;
            else r = 32'd0 - q[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ddo_if.sv =====
// ddo_if: sample and pose channel interfaces with valid/ready handshake
// depends on ddo_pkg for field widths
`default_nettype none

interface ddo_sample_if
    import ddo_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [TIME_W-1:0]         sample_time;
    logic signed [COUNT_W-1:0] left_count;
    logic signed [COUNT_W-1:0] right_count;

    modport source (output valid, output sample_time, output left_count,
                    output right_count, input ready);
    modport sink (input valid, input sample_time, input left_count,
                  input right_count, output ready);
endinterface

interface ddo_pose_if
    import ddo_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [ANGLE_W-1:0] heading;
    logic signed [VEL_W-1:0]   vel_x;
    logic signed [VEL_W-1:0]   vel_y;
    logic signed [VEL_W-1:0]   yaw_rate;
    logic                      dt_zero;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    output vel_x, output vel_y, output yaw_rate, output dt_zero,
                    input ready);
    modport sink (input valid, input pos_x, input pos_y, input heading,
                  input vel_x, input vel_y, input yaw_rate, input dt_zero,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/ddo_datapath.sv =====
// ddo_datapath: registers, shared 32x32 multiplier, serial divider and cordic
// depends on ddo_pkg; driven by ddo_ctrl through ddo_cmd_t
`default_nettype none

module ddo_datapath
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = DEFAULT_CORDIC_STEPS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [TIME_W-1:0]         sample_time,
    input  wire logic [COUNT_W-1:0]        left_count,
    input  wire logic [COUNT_W-1:0]        right_count,
    input  wire ddo_cmd_t                  cmd,
    output ddo_status_t                    status,
    input  wire logic                      out_ready,
    output logic                           out_valid,
    output logic [POS_W-1:0]               pos_x,
    output logic [POS_W-1:0]               pos_y,
    output logic [ANGLE_W-1:0]             heading,
    output logic [VEL_W-1:0]               vel_x,
    output logic [VEL_W-1:0]               vel_y,
    output logic [VEL_W-1:0]               yaw_rate,
    output logic                           dt_zero
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);

    // configuration and odometry state
    logic [SCALE_W-1:0] lscale_reg, rscale_reg;
    logic [TRACK_W-1:0] htrack_reg;
    logic               have_prev_reg;
    logic [31:0]        prev_time_reg, prev_left_reg, prev_right_reg;
    logic [31:0]        heading_reg;
    logic [47:0]        x_acc_reg, y_acc_reg;
    logic               out_valid_reg;

    // working registers
    logic [31:0]        dt_reg, dlc_reg, drc_reg;
    logic               dt_zero_reg;
    logic [63:0]        p_reg;
    logic [87:0]        acc_reg;
    logic [55:0]        dl_reg, dr_reg;
    logic [55:0]        ddm_reg, sm_reg;
    logic               ddneg_reg, sumneg_reg;
    logic [DIV_DEN_W-1:0] den_reg, rem_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [32:0]        q_reg;
    logic               ovf_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg;
    logic [CNT_W-1:0]   ccnt_reg;
    logic [31:0]        cosmag_reg, sinmag_reg;
    logic               cosneg_reg, sinneg_reg;
    logic [55:0]        mx_reg, my_reg;
    logic               nx_reg, ny_reg;
    logic [31:0]        vx_reg, vy_reg, yaw_reg;
    logic [47:0]        pos_x_reg, pos_y_reg;
    logic [31:0]        heading_out_reg, vx_out_reg, vy_out_reg, yaw_out_reg;
    logic               dtz_out_reg;

    // combinational helpers
    logic [31:0]        mag_l, mag_r, mul_a, mul_b;
    logic [23:0]        ht;
    logic [63:0]        prod;
    logic [55:0]        trav_mag, trav_next;
    logic               trav_neg;
    logic [56:0]        dd_full, sum_full, dd_abs, sum_abs;
    logic [56:0]        rem2, den_ext, rem_sub;
    logic               ge;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_NUM_W-1:0] num_next;
    logic [DIV_DEN_W-1:0] den_next;
    logic [31:0]        dq, head_add;
    logic               flip_next;
    logic [31:0]        ang_f;
    logic [4:0]         csh;
    logic signed [33:0] xs, ys, at, cos_v, sin_v, cos_abs, sin_abs;
    logic [31:0]        sat_q_pos, sat_q_neg_x, sat_q_neg_y, sat_q_yaw;

    assign ht    = (htrack_reg == '0) ? 24'd1 : htrack_reg;
    assign mag_l = dlc_reg[31] ? (32'd0 - dlc_reg) : dlc_reg;
    assign mag_r = drc_reg[31] ? (32'd0 - drc_reg) : drc_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_L:    begin mul_a = mag_l;                mul_b = lscale_reg;  end
            MUL_R:    begin mul_a = mag_r;                mul_b = rscale_reg;  end
            MUL_PIHT: begin mul_a = PI_Q29;               mul_b = {8'd0, ht};  end
            MUL_C_LO: begin mul_a = sm_reg[31:0];         mul_b = cosmag_reg;  end
            MUL_C_HI: begin mul_a = {8'd0, sm_reg[55:32]}; mul_b = cosmag_reg; end
            MUL_S_LO: begin mul_a = sm_reg[31:0];         mul_b = sinmag_reg;  end
            MUL_S_HI: begin mul_a = {8'd0, sm_reg[55:32]}; mul_b = sinmag_reg; end
            MUL_X_LO: begin mul_a = mx_reg[31:0];         mul_b = USEC_PER_S;  end
            MUL_X_HI: begin mul_a = {8'd0, mx_reg[55:32]}; mul_b = USEC_PER_S; end
            MUL_Y_LO: begin mul_a = my_reg[31:0];         mul_b = USEC_PER_S;  end
            MUL_Y_HI: begin mul_a = {8'd0, my_reg[55:32]}; mul_b = USEC_PER_S; end
            MUL_D_LO: begin mul_a = ddm_reg[31:0];        mul_b = USEC_PER_S;  end
            MUL_D_HI: begin mul_a = {8'd0, ddm_reg[55:32]}; mul_b = USEC_PER_S; end
            MUL_HTDT: begin mul_a = {8'd0, ht};           mul_b = dt_reg;      end
            default:  begin mul_a = '0;                   mul_b = '0;          end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    // wheel travel: magnitude product >> 8, sign of the count delta
    assign trav_mag  = {1'b0, p_reg[62:8]};
    assign trav_neg  = cmd.set_dl ? dlc_reg[31] : drc_reg[31];
    assign trav_next = trav_neg ? (56'd0 - trav_mag) : trav_mag;

    assign dd_full  = {dl_reg[55], dl_reg} - {dr_reg[55], dr_reg};
    assign sum_full = {dl_reg[55], dl_reg} + {dr_reg[55], dr_reg};
    assign dd_abs   = dd_full[56] ? (57'd0 - dd_full) : dd_full;
    assign sum_abs  = sum_full[56] ? (57'd0 - sum_full) : sum_full;

    // restoring divider, one quotient bit per cycle
    assign rem2     = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign den_ext  = {1'b0, den_reg};
    assign ge       = (rem2 >= den_ext);
    assign rem_sub  = rem2 - den_ext;
    assign rem_next = ge ? rem_sub[DIV_DEN_W-1:0] : rem2[DIV_DEN_W-1:0];

    always_comb
    begin
        case (cmd.num_sel)
            NUM_DBA:   num_next = {1'b0, ddm_reg, 59'd0};
            NUM_ACC:   num_next = {28'd0, acc_reg};
            NUM_ACC15: num_next = {13'd0, acc_reg, 15'd0};
            default:   num_next = '0;
        endcase
    end

    assign den_next = (cmd.den_sel == DEN_DT) ? {24'd0, dt_reg} : p_reg[DIV_DEN_W-1:0];

    assign dq       = q_reg[31:0];
    assign head_add = ddneg_reg ? (32'd0 - dq) : dq;

    // cordic
    assign flip_next = (heading_reg > 32'h40000000) && (heading_reg < 32'hC0000000);
    assign ang_f     = flip_next ? (heading_reg ^ 32'h80000000) : heading_reg;
    assign csh       = 5'(ccnt_reg);
    assign xs        = cx_reg >>> csh;
    assign ys        = cy_reg >>> csh;
    assign at        = signed'({2'b00, atan_entry(csh)});
    assign cos_v     = flip_reg ? -cx_reg : cx_reg;
    assign sin_v     = flip_reg ? -cy_reg : cy_reg;
    assign cos_abs   = cos_v[33] ? -cos_v : cos_v;
    assign sin_abs   = sin_v[33] ? -sin_v : sin_v;

    assign sat_q_pos   = sat32(nx_reg, ovf_reg, q_reg);
    assign sat_q_neg_x = sat_q_pos;
    assign sat_q_neg_y = sat32(ny_reg, ovf_reg, q_reg);
    assign sat_q_yaw   = sat32(ddneg_reg, ovf_reg, q_reg);

    // state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lscale_reg     <= '0;
            rscale_reg     <= '0;
            htrack_reg     <= HALF_TRACK_RESET;
            have_prev_reg  <= 1'b0;
            prev_time_reg  <= '0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            heading_reg    <= '0;
            x_acc_reg      <= '0;
            y_acc_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_LEFT_SCALE:  lscale_reg <= cfg_data;
                    REG_RIGHT_SCALE: rscale_reg <= cfg_data;
                    REG_HALF_TRACK:  htrack_reg <= cfg_data[TRACK_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.capture) begin
                have_prev_reg  <= 1'b1;
                prev_time_reg  <= sample_time;
                prev_left_reg  <= left_count;
                prev_right_reg <= right_count;
            end
            if (cmd.set_head) begin
                heading_reg <= heading_reg + head_add;
            end
            if (cmd.pos_upd) begin
                x_acc_reg <= x_acc_reg + (nx_reg ? (48'd0 - mx_reg[47:0]) : mx_reg[47:0]);
                y_acc_reg <= y_acc_reg + (ny_reg ? (48'd0 - my_reg[47:0]) : my_reg[47:0]);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture) begin
            dt_reg      <= sample_time - prev_time_reg;
            dt_zero_reg <= (sample_time == prev_time_reg);
            dlc_reg     <= left_count - prev_left_reg;
            drc_reg     <= right_count - prev_right_reg;
        end
        if (cmd.mul_en) begin
            p_reg <= prod;
        end
        if (cmd.set_dl) begin
            dl_reg <= trav_next;
        end
        if (cmd.set_dr) begin
            dr_reg <= trav_next;
        end
        if (cmd.set_diff) begin
            ddneg_reg  <= dd_full[56];
            ddm_reg    <= dd_abs[55:0];
            sumneg_reg <= sum_full[56];
            sm_reg     <= sum_abs[55:0];
        end
        if (cmd.acc_load) begin
            acc_reg <= {24'd0, p_reg};
        end
        else if (cmd.acc_add) begin
            acc_reg <= acc_reg + 88'({p_reg, 32'd0});
        end
        if (cmd.den_load) begin
            den_reg <= den_next;
        end
        if (cmd.num_load) begin
            num_reg  <= num_next;
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step) begin
            num_reg  <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            q_reg    <= {q_reg[31:0], ge};
            ovf_reg  <= ovf_reg | q_reg[32];
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.cord_init) begin
            cx_reg   <= signed'(CORDIC_GAIN);
            cy_reg   <= '0;
            cz_reg   <= signed'({{2{ang_f[31]}}, ang_f});
            flip_reg <= flip_next;
            ccnt_reg <= '0;
        end
        else if (cmd.cord_step) begin
            if (!cz_reg[33]) begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - at;
            end
            else begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + at;
            end
            ccnt_reg <= ccnt_reg + 1'b1;
        end
        if (cmd.cord_fin) begin
            cosmag_reg <= cos_abs[31:0];
            cosneg_reg <= cos_v[33];
            sinmag_reg <= sin_abs[31:0];
            sinneg_reg <= sin_v[33];
        end
        if (cmd.set_mx) begin
            mx_reg <= acc_reg[86:31];
            nx_reg <= sumneg_reg ^ cosneg_reg;
        end
        if (cmd.set_my) begin
            my_reg <= acc_reg[86:31];
            ny_reg <= sumneg_reg ^ sinneg_reg;
        end
        if (cmd.set_vx) begin
            vx_reg <= sat_q_neg_x;
        end
        if (cmd.set_vy) begin
            vy_reg <= sat_q_neg_y;
        end
        if (cmd.set_yaw) begin
            yaw_reg <= sat_q_yaw;
        end
        if (cmd.out_load) begin
            pos_x_reg       <= x_acc_reg;
            pos_y_reg       <= y_acc_reg;
            heading_out_reg <= heading_reg;
            vx_out_reg      <= dt_zero_reg ? 32'd0 : vx_reg;
            vy_out_reg      <= dt_zero_reg ? 32'd0 : vy_reg;
            yaw_out_reg     <= dt_zero_reg ? 32'd0 : yaw_reg;
            dtz_out_reg     <= dt_zero_reg;
        end
    end

    assign status.have_prev = have_prev_reg;
    assign status.dt_zero   = dt_zero_reg;
    assign status.div_last  = (dcnt_reg == DIV_LAST);
    assign status.cord_last = (ccnt_reg == CORD_LAST);
    assign status.out_busy  = out_valid_reg & ~out_ready;

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign heading   = heading_out_reg;
    assign vel_x     = vx_out_reg;
    assign vel_y     = vy_out_reg;
    assign yaw_rate  = yaw_out_reg;
    assign dt_zero   = dtz_out_reg;

endmodule

`default_nettype wire

// ===== rtl/ddo_ctrl.sv =====
// ddo_ctrl: sequencer for one odometry update
// depends on ddo_pkg; commands ddo_datapath, reads its status
`default_nettype none

module ddo_ctrl
    import ddo_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire ddo_status_t status,
    output ddo_cmd_t         cmd
);

    localparam int ST_W = 38;

    typedef enum logic [ST_W-1:0] {
        S_IDLE  = 38'b1 << 0,
        S_ML    = 38'b1 << 1,
        S_MR    = 38'b1 << 2,
        S_MPI   = 38'b1 << 3,
        S_DIFF  = 38'b1 << 4,
        S_HLOAD = 38'b1 << 5,
        S_HDIV  = 38'b1 << 6,
        S_HEAD  = 38'b1 << 7,
        S_CINIT = 38'b1 << 8,
        S_CORD  = 38'b1 << 9,
        S_CFIN  = 38'b1 << 10,
        S_CLO   = 38'b1 << 11,
        S_CHI   = 38'b1 << 12,
        S_CADD  = 38'b1 << 13,
        S_SHI   = 38'b1 << 14,
        S_SADD  = 38'b1 << 15,
        S_MY    = 38'b1 << 16,
        S_POS   = 38'b1 << 17,
        S_XLO   = 38'b1 << 18,
        S_XHI   = 38'b1 << 19,
        S_XADD  = 38'b1 << 20,
        S_XNUM  = 38'b1 << 21,
        S_XDIV  = 38'b1 << 22,
        S_VX    = 38'b1 << 23,
        S_YLO   = 38'b1 << 24,
        S_YHI   = 38'b1 << 25,
        S_YADD  = 38'b1 << 26,
        S_YNUM  = 38'b1 << 27,
        S_YDIV  = 38'b1 << 28,
        S_VY    = 38'b1 << 29,
        S_HTDT  = 38'b1 << 30,
        S_DLO   = 38'b1 << 31,
        S_DHI   = 38'b1 << 32,
        S_DADD  = 38'b1 << 33,
        S_DNUM  = 38'b1 << 34,
        S_DDIV  = 38'b1 << 35,
        S_YAW   = 38'b1 << 36,
        S_OUT   = 38'b1 << 37
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    if (status.have_prev) state_next = S_ML;
                end
            end
            S_ML: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_L;
                state_next = S_MR;
            end
            S_MR: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_R; cmd.set_dl = 1'b1;
                state_next = S_MPI;
            end
            S_MPI: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_PIHT; cmd.set_dr = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                cmd.set_diff = 1'b1;
                state_next   = S_HLOAD;
            end
            S_HLOAD: begin
                cmd.den_load = 1'b1; cmd.den_sel = DEN_P;
                cmd.num_load = 1'b1; cmd.num_sel = NUM_DBA;
                state_next   = S_HDIV;
            end
            S_HDIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) state_next = S_HEAD;
            end
            S_HEAD: begin
                cmd.set_head = 1'b1;
                state_next   = S_CINIT;
            end
            S_CINIT: begin
                cmd.cord_init = 1'b1;
                state_next    = S_CORD;
            end
            S_CORD: begin
                cmd.cord_step = 1'b1;
                if (status.cord_last) state_next = S_CFIN;
            end
            S_CFIN: begin
                cmd.cord_fin = 1'b1;
                state_next   = S_CLO;
            end
            S_CLO: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_C_LO;
                state_next = S_CHI;
            end
            S_CHI: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_C_HI; cmd.acc_load = 1'b1;
                state_next = S_CADD;
            end
            S_CADD: begin
                cmd.acc_add = 1'b1; cmd.mul_en = 1'b1; cmd.mul_sel = MUL_S_LO;
                state_next  = S_SHI;
            end
            S_SHI: begin
                cmd.set_mx   = 1'b1;
                cmd.mul_en   = 1'b1; cmd.mul_sel = MUL_S_HI;
                cmd.acc_load = 1'b1;
                state_next   = S_SADD;
            end
            S_SADD: begin
                cmd.acc_add = 1'b1;
                state_next  = S_MY;
            end
            S_MY: begin
                cmd.set_my = 1'b1;
                state_next = S_POS;
            end
            S_POS: begin
                cmd.pos_upd = 1'b1;
                state_next  = status.dt_zero ? S_OUT : S_XLO;
            end
            S_XLO: begin
                cmd.mul_en   = 1'b1; cmd.mul_sel = MUL_X_LO;
                cmd.den_load = 1'b1; cmd.den_sel = DEN_DT;
                state_next   = S_XHI;
            end
            S_XHI: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_X_HI; cmd.acc_load = 1'b1;
                state_next = S_XADD;
            end
            S_XADD: begin
                cmd.acc_add = 1'b1;
                state_next  = S_XNUM;
            end
            S_XNUM: begin
                cmd.num_load = 1'b1; cmd.num_sel = NUM_ACC;
                state_next   = S_XDIV;
            end
            S_XDIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) state_next = S_VX;
            end
            S_VX: begin
                cmd.set_vx = 1'b1;
                state_next = S_YLO;
            end
            S_YLO: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_Y_LO;
                state_next = S_YHI;
            end
            S_YHI: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_Y_HI; cmd.acc_load = 1'b1;
                state_next = S_YADD;
            end
            S_YADD: begin
                cmd.acc_add = 1'b1;
                state_next  = S_YNUM;
            end
            S_YNUM: begin
                cmd.num_load = 1'b1; cmd.num_sel = NUM_ACC;
                state_next   = S_YDIV;
            end
            S_YDIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) state_next = S_VY;
            end
            S_VY: begin
                cmd.set_vy = 1'b1;
                state_next = S_HTDT;
            end
            S_HTDT: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_HTDT;
                state_next = S_DLO;
            end
            S_DLO: begin
                cmd.den_load = 1'b1; cmd.den_sel = DEN_P;
                cmd.mul_en   = 1'b1; cmd.mul_sel = MUL_D_LO;
                state_next   = S_DHI;
            end
            S_DHI: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_D_HI; cmd.acc_load = 1'b1;
                state_next = S_DADD;
            end
            S_DADD: begin
                cmd.acc_add = 1'b1;
                state_next  = S_DNUM;
            end
            S_DNUM: begin
                cmd.num_load = 1'b1; cmd.num_sel = NUM_ACC15;
                state_next   = S_DDIV;
            end
            S_DDIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) state_next = S_YAW;
            end
            S_YAW: begin
                cmd.set_yaw = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/diff_drive_odometry_top.sv =====
// diff_drive_odometry_top: differential drive wheel odometry, top level
// depends on ddo_pkg, ddo_if, ddo_ctrl and ddo_datapath
`default_nettype none

// channel    dir  handshake          payload
// cfg        in   cfg_we (no ready)  cfg_index, cfg_data
// sample_in  in   valid / ready      sample_time, left_count, right_count
// pose_out   out  valid / ready      pos_x, pos_y, heading, vel_x, vel_y, yaw_rate, dt_zero
//
// one sample at a time: a first sample only primes the state
// a normal update runs the 1-bit-per-cycle divider four times
// with a zero time delta the three velocity divides are skipped
// the result sits in an output register, so a stalled sink only holds the
// sequencer in its final state; async active-low reset resets pose and config

module diff_drive_odometry_top
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = DEFAULT_CORDIC_STEPS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    ddo_sample_if.sink                 sample_in,
    ddo_pose_if.source                 pose_out
);

    ddo_cmd_t    cmd;
    ddo_status_t status;
    logic [POS_W-1:0]   pos_x, pos_y;
    logic [ANGLE_W-1:0] heading;
    logic [VEL_W-1:0]   vel_x, vel_y, yaw_rate;
    logic               dt_zero;
    logic               out_valid;
    logic               in_ready;

    // sequencer: one-hot state machine stepping the datapath
    ddo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: shared multiplier, serial divider, cordic and state
    ddo_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_time (sample_in.sample_time),
        .left_count  (sample_in.left_count),
        .right_count (sample_in.right_count),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (pose_out.ready),
        .out_valid   (out_valid),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .heading     (heading),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .yaw_rate    (yaw_rate),
        .dt_zero     (dt_zero)
    );

    // drive the channel signals
    assign sample_in.ready   = in_ready;
    assign pose_out.valid    = out_valid;
    assign pose_out.pos_x    = pos_x;
    assign pose_out.pos_y    = pos_y;
    assign pose_out.heading  = heading;
    assign pose_out.vel_x    = vel_x;
    assign pose_out.vel_y    = vel_y;
    assign pose_out.yaw_rate = yaw_rate;
    assign pose_out.dt_zero  = dt_zero;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench: self-checking bench for diff_drive_odometry_top, wheel samples in, pose out
// depends on rtl/ddo_pkg.sv, rtl/ddo_if.sv and the odometry rtl; no files or arguments
// a scoreboard class predicts each pose from its own copy of the odometry state
`default_nettype none

module testbench;
    import ddo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // index past the last register, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int CORDIC_ITERS = DEFAULT_CORDIC_STEPS;
    localparam int SETTLE_CYCLES = 700;
    localparam int HOLD_CYCLES = 3000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS = 245;

    typedef struct packed {
        logic [TIME_W-1:0]         sample_time;
        logic signed [COUNT_W-1:0] left_count;
        logic signed [COUNT_W-1:0] right_count;
    } sample_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [ANGLE_W-1:0] heading;
        logic signed [VEL_W-1:0]   vel_x;
        logic signed [VEL_W-1:0]   vel_y;
        logic signed [VEL_W-1:0]   yaw_rate;
        logic                      dt_zero;
    } pose_t;

    // arctangent of 2^-i as a binary angle
    localparam logic [31:0] ATAN_BA [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    class odometry_scoreboard;
        logic [SCALE_W-1:0] left_scale;
        logic [SCALE_W-1:0] right_scale;
        logic [TRACK_W-1:0] half_track;
        bit                 primed;
        logic [31:0]        last_time;
        logic [31:0]        last_left;
        logic [31:0]        last_right;
        logic [31:0]        heading_ba;
        logic [POS_W-1:0]   x_pos;
        logic [POS_W-1:0]   y_pos;
        pose_t              poses_due[$];
        int                 errors;

        function new();
            left_scale = '0;
            right_scale = '0;
            half_track = HALF_TRACK_RESET;
            primed = 0;
            last_time = '0;
            last_left = '0;
            last_right = '0;
            heading_ba = '0;
            x_pos = '0;
            y_pos = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_LEFT_SCALE:  left_scale = val;
                REG_RIGHT_SCALE: right_scale = val;
                REG_HALF_TRACK:  half_track = val[TRACK_W-1:0];
                default: ;
            endcase
        endfunction

        // Q.16 meters of travel, magnitude truncated before the sign goes on
        function longint travel(logic [31:0] delta, logic [31:0] scale);
            logic [63:0] mag;
            logic [63:0] m;
            mag = delta[31] ? (64'h1_0000_0000 - delta) : {32'b0, delta};
            m = (mag * {32'b0, scale}) >> 8;
            return delta[31] ? -longint'(m) : longint'(m);
        endfunction

        function logic [31:0] clamp32(bit neg, logic [127:0] q);
            if (!neg)
                return (q > 128'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
            return (q > 128'h80000000) ? 32'h80000000 : (32'd0 - q[31:0]);
        endfunction

        function void rotate(logic [31:0] ang, output longint c, output longint s);
            longint x, y, z, xs, ys;
            logic [31:0] a;
            bit flip;
            x = longint'(CORDIC_GAIN);
            y = 0;
            a = ang;
            flip = 0;
            if (a > 32'h40000000 && a < 32'hC0000000) begin
                a = a ^ 32'h80000000;
                flip = 1;
            end
            z = longint'($signed(a));
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(ATAN_BA[i]);
                end
                else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(ATAN_BA[i]);
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        // travel sum times a Q.30 trig value, back to Q.16
        function logic [63:0] project(longint sum, longint trig, output bit neg);
            logic [127:0] p;
            logic [63:0] sm, tm;
            sm = (sum < 0) ? -sum : sum;
            tm = (trig < 0) ? -trig : trig;
            p = {64'b0, sm} * {64'b0, tm};
            neg = (sum < 0) != (trig < 0);
            return p[94:31];
        endfunction

        function logic [31:0] speed(logic [63:0] mag, bit neg, logic [31:0] dt);
            logic [127:0] q;
            q = ({64'b0, mag} * 128'd1000000) / {96'b0, dt};
            return clamp32(neg, q);
        endfunction

        function void note_sample(sample_t smp);
            logic [31:0] dt, step, ht;
            longint dl, dr, diff, sum, c, s;
            logic [63:0] diff_mag, mx, my;
            logic [127:0] q;
            bit diff_neg, nx, ny;
            pose_t p;
            if (!primed) begin
                // first sample only primes the history
                last_time = smp.sample_time;
                last_left = smp.left_count;
                last_right = smp.right_count;
                primed = 1;
                return;
            end
            dt = smp.sample_time - last_time;
            dl = travel(smp.left_count - last_left, left_scale);
            dr = travel(smp.right_count - last_right, right_scale);
            last_time = smp.sample_time;
            last_left = smp.left_count;
            last_right = smp.right_count;
            ht = (half_track == 0) ? 32'd1 : {8'b0, half_track};
            diff = dl - dr;
            sum = dl + dr;
            diff_neg = diff < 0;
            diff_mag = diff_neg ? -diff : diff;
            q = ({64'b0, diff_mag} << 59) / ({96'b0, PI_Q29} * {96'b0, ht});
            step = diff_neg ? (32'd0 - q[31:0]) : q[31:0];
            heading_ba = heading_ba + step;
            rotate(heading_ba, c, s);
            mx = project(sum, c, nx);
            my = project(sum, s, ny);
            x_pos = x_pos + (nx ? (48'd0 - mx[47:0]) : mx[47:0]);
            y_pos = y_pos + (ny ? (48'd0 - my[47:0]) : my[47:0]);
            p.pos_x = x_pos;
            p.pos_y = y_pos;
            p.heading = heading_ba;
            if (dt == 0) begin
                p.vel_x = '0;
                p.vel_y = '0;
                p.yaw_rate = '0;
                p.dt_zero = 1'b1;
            end
            else begin
                p.vel_x = speed(mx, nx, dt);
                p.vel_y = speed(my, ny, dt);
                q = ({64'b0, diff_mag} * 128'd32768000000) / ({96'b0, ht} * {96'b0, dt});
                p.yaw_rate = clamp32(diff_neg, q);
                p.dt_zero = 1'b0;
            end
            poses_due.push_back(p);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check(pose_t got);
            pose_t want;
            if (poses_due.size() == 0) begin
                report("pose transfer with no pose pending");
                return;
            end
            want = poses_due.pop_front();
            if (got.pos_x !== want.pos_x)
                report($sformatf("pos_x got %h want %h", got.pos_x, want.pos_x));
            if (got.pos_y !== want.pos_y)
                report($sformatf("pos_y got %h want %h", got.pos_y, want.pos_y));
            if (got.heading !== want.heading)
                report($sformatf("heading got %h want %h", got.heading, want.heading));
            if (got.vel_x !== want.vel_x)
                report($sformatf("vel_x got %h want %h", got.vel_x, want.vel_x));
            if (got.vel_y !== want.vel_y)
                report($sformatf("vel_y got %h want %h", got.vel_y, want.vel_y));
            if (got.yaw_rate !== want.yaw_rate)
                report($sformatf("yaw_rate got %h want %h", got.yaw_rate, want.yaw_rate));
            if (got.dt_zero !== want.dt_zero)
                report($sformatf("dt_zero got %b want %b", got.dt_zero, want.dt_zero));
        endtask

        function int pending();
            return poses_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ddo_sample_if sin();
    ddo_pose_if pout();

    diff_drive_odometry_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_in (sin),
        .pose_out  (pout)
    );

    odometry_scoreboard sb;

    // running wheel and clock position of the robot being simulated
    logic [31:0] cur_time;
    logic [31:0] cur_left;
    logic [31:0] cur_right;
    int burst_left;
    bit hold_req;

    // 2 ns clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // every input known from time zero
    initial
    begin
        sin.valid = 1'b0;
        sin.sample_time = '0;
        sin.left_count = '0;
        sin.right_count = '0;
        pout.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_req = 0;
    end

    // pose checker: sample the transfer on the edge that completes it
    always @(posedge clk)
    begin
        if (rst_n && pout.valid && pout.ready)
            sb.check('{pout.pos_x, pout.pos_y, pout.heading, pout.vel_x, pout.vel_y,
                       pout.yaw_rate, pout.dt_zero});
    end

    // receiver: stretches of steady, patchy or rare ready, plus a long hold-off in each random phase
    initial
    begin
        int mode;
        int span;
        @(posedge rst_n);
        forever
        begin
            if (hold_req) begin
                pout.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 200);
                repeat (span)
                begin
                    case (mode)
                        0, 1: pout.ready <= 1'b1;
                        2: pout.ready <= 1'($urandom_range(0, 1));
                        default: pout.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // watchdog: too long without any transfer means the block hung
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((sin.valid && sin.ready) || (pout.valid && pout.ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", quiet);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // offer one sample and hold it until the transfer, then maybe idle a while
    task send_sample(logic [31:0] t, logic [31:0] l, logic [31:0] r);
        sin.valid <= 1'b1;
        sin.sample_time <= t;
        sin.left_count <= l;
        sin.right_count <= r;
        do
            @(posedge clk);
        while (!sin.ready);
        sb.note_sample('{t, l, r});
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0) begin
                sin.valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    endtask

    // advance the robot by the given deltas and send the new sample
    task move(logic [31:0] dt, logic [31:0] dl, logic [31:0] dr);
        cur_time = cur_time + dt;
        cur_left = cur_left + dl;
        cur_right = cur_right + dr;
        send_sample(cur_time, cur_left, cur_right);
    endtask

    // wait for the block to drain, then write all three registers
    task configure(logic [31:0] ls, logic [31:0] rs, logic [31:0] ht);
        sin.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_LEFT_SCALE;
        cfg_data <= ls;
        @(posedge clk);
        sb.set_reg(REG_LEFT_SCALE, ls);
        cfg_index <= REG_RIGHT_SCALE;
        cfg_data <= rs;
        @(posedge clk);
        sb.set_reg(REG_RIGHT_SCALE, rs);
        cfg_index <= REG_HALF_TRACK;
        cfg_data <= ht;
        @(posedge clk);
        sb.set_reg(REG_HALF_TRACK, ht);
        // the spare index must change nothing
        cfg_index <= REG_SPARE;
        cfg_data <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // signed count delta with a random magnitude range
    function logic [31:0] rand_delta();
        int k;
        logic [31:0] v;
        k = $urandom_range(0, 31);
        v = $urandom & ((32'd1 << k) - 1);
        return $urandom_range(0, 1) ? (32'd0 - v) : v;
    endfunction

    task random_phase(int n);
        int kind;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
                // noise: random counts, time either random or left as it was
                send_sample(($urandom_range(0, 1) ? cur_time : $urandom), $urandom, $urandom);
            else if (kind == 1)
                move(32'd0, rand_delta(), rand_delta());
            else if (kind == 2)
                move($urandom, rand_delta(), rand_delta());
            else
                move($urandom_range(1, 20000), rand_delta(), rand_delta());
            if (i == n / 2 && n > 100)
                hold_req = 1;
        end
    endtask

    initial
    begin
        sb = new();
        burst_left = 0;
        cur_time = 32'd1000;
        cur_left = 32'd0;
        cur_right = 32'd0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config, scales at zero: travel is zero whatever the counts
        send_sample(cur_time, cur_left, cur_right);
        move(32'd100, 32'd500, 32'hFFFF_FF00);

        // about 1/256 m per tick, default track
        configure(32'h0001_0000, 32'h0001_0000, 32'(HALF_TRACK_RESET));
        move(32'd1000, 32'd100, 32'd100);
        move(32'd0, 32'd50, 32'd10);
        move(32'd1000, 32'd0, 32'd0);
        move(32'd1000, 32'h7FFF_FFFF, 32'h8000_0001);
        move(32'd1000, 32'h8000_0000, 32'd0);
        move(32'd1000, 32'd0, 32'h8000_0000);
        move(32'd1000, 32'd4000, 32'hFFFF_F000);
        // time wraps around its 32-bit range
        cur_time = 32'hFFFF_FF00;
        move(32'd0, 32'd0, 32'd0);
        move(32'h0000_0200, 32'd200, 32'd300);
        move(32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        move(32'hFFFF_FFFF, 32'd3, 32'hFFFF_FFFD);
        // keep turning so the heading passes both quarter turns and pi
        for (int i = 0; i < 8; i++)
            move(32'd500, 32'd3000, 32'hFFFF_F000);
        send_sample(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000);

        random_phase(PHASE_ITEMS);
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        random_phase(PHASE_ITEMS);
        // zero track is taken as one
        configure(32'h0000_0001, 32'h0000_0000, 32'd0);
        random_phase(PHASE_ITEMS);
        configure(32'h00FF_FFFF, 32'h0100_0000, 32'h00FF_FFFF);
        random_phase(PHASE_ITEMS);
        configure($urandom, $urandom, $urandom_range(1, 32'h00FF_FFFF));
        random_phase(PHASE_ITEMS - 30);

        sin.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
